// File: design/rbr_pkg.sv
// Package for the relative bearing and range core: item types, widths,
// angle constants and the CORDIC arctangent table. No dependencies.
package rbr_pkg;

  // Number of CORDIC rotations and the length of the arctangent table.
  localparam int CORDIC_STAGES = 16;
  localparam int ANG_TAB_LEN   = 24;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < ANG_TAB_LEN) ? CORDIC_STAGES : ANG_TAB_LEN;

  // Widths of the datapath.
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;     // target minus robot
  localparam int PROD_W  = DIFF_W + 16;     // difference times Q1.14 vector
  localparam int PROJ_W  = PROD_W + 1;      // sum of two products
  localparam int SQ_W    = 34;              // dx^2 + dz^2
  localparam int SQRT_STEPS = SQ_W / 2;     // one result bit per step
  localparam int XY_W    = 45;              // CORDIC x and y with growth
  localparam int Z_W     = 32;              // angle accumulator
  localparam int BEAR_W  = 16;
  localparam int DIST_W  = 17;

  localparam int LOOP_STAGES = (CORDIC_RUN > SQRT_STEPS) ? CORDIC_RUN : SQRT_STEPS;

  // Angles in degrees * 128 * 65536.
  localparam logic signed [Z_W-1:0] ANG_90  = 32'sd754974720;
  localparam logic signed [Z_W-1:0] ANG_180 = 32'sd1509949440;
  localparam logic [Z_W-1:0]        ROUND_HALF = 32'd32768;

  localparam logic signed [BEAR_W-1:0] BEARING_MAX = 16'sd23040;
  localparam logic [DIST_W-1:0]        DIST_MAX    = 17'd92682;

  typedef struct packed {
    logic signed [COORD_W-1:0] robot_x;
    logic signed [COORD_W-1:0] robot_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] front_x;
    logic signed [COORD_W-1:0] front_z;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] right_z;
  } in_item_t;

  typedef struct packed {
    logic signed [BEAR_W-1:0] bearing;
    logic [DIST_W-1:0]        distance;
    logic                     coincident;
  } out_item_t;

  // atan(2^-i) in degrees * 128 * 65536.
  function automatic logic signed [Z_W-1:0] atan_ang(input int idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      0:  a = 32'sd377487360;
      1:  a = 32'sd222843801;
      2:  a = 32'sd117744544;
      3:  a = 32'sd59768969;
      4:  a = 32'sd30000467;
      5:  a = 32'sd15014858;
      6:  a = 32'sd7509261;
      7:  a = 32'sd3754860;
      8:  a = 32'sd1877459;
      9:  a = 32'sd938733;
      10: a = 32'sd469367;
      11: a = 32'sd234683;
      12: a = 32'sd117342;
      13: a = 32'sd58671;
      14: a = 32'sd29335;
      15: a = 32'sd14668;
      16: a = 32'sd7334;
      17: a = 32'sd3667;
      18: a = 32'sd1833;
      19: a = 32'sd917;
      20: a = 32'sd458;
      21: a = 32'sd229;
      22: a = 32'sd115;
      23: a = 32'sd57;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: design/relative_bearing_and_range_core.sv
// Top level of the relative bearing and range core: a fully pipelined
// CORDIC vectoring unit beside a pipelined integer square root. Uses rbr_pkg.
//
// This core takes one item per clock cycle while the output is not stalled and
// returns, for each item, the signed bearing of the target seen from the robot
// (1/128 degree, negative on the left of the right vector) and the floor of the
// Euclidean distance. The stages, in order: one forms the offset, one the six
// products, one the two projections and the squared length, one loads the
// CORDIC, then the rotation and root stages (the 17-step square root sets their
// number at the default of sixteen rotations), and the rounding into the output
// register. Every stage carries its own valid bit and only holds when the stage
// after it is full and stalled, so back-pressure on the result side fills
// bubbles first and never drops or repeats an item.
// A target at the robot position raises coincident with bearing and distance 0.
module relative_bearing_and_range_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbr_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rbr_pkg::out_item_t out_data
);
  import rbr_pkg::*;

  // One slot of the rotation and square root pipeline.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        n;
    logic [SQ_W-1:0]        res;
    logic                   qneg;
    logic                   zero_bear;
    logic                   coinc;
  } slot_t;

  // ---------------------------------------------------------------------------
  // Stage enables. A stage loads when it is empty or the stage below moves on.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic en_s1, en_s2, en_s3, en_out;
  logic en_p [0:LOOP_STAGES];
  logic pv_r [0:LOOP_STAGES];

  assign en_out = !out_valid_r || out_ready;
  assign en_p[LOOP_STAGES] = !pv_r[LOOP_STAGES] || en_out;
  assign en_s3 = !s3_v_r || en_p[0];
  assign en_s2 = !s2_v_r || en_s3;
  assign en_s1 = !s1_v_r || en_s2;
  assign in_ready = en_s1;

  // ---------------------------------------------------------------------------
  // Stage 1: offset from robot to target, vectors registered.
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]  dx_r, dz_r, dx_nxt, dz_nxt;
  logic signed [COORD_W-1:0] fx_r, fz_r, rx_r, rz_r;

  assign dx_nxt = DIFF_W'(in_data.target_x) - DIFF_W'(in_data.robot_x);
  assign dz_nxt = DIFF_W'(in_data.target_z) - DIFF_W'(in_data.robot_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en_s1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      dx_r <= dx_nxt;
      dz_r <= dz_nxt;
      fx_r <= in_data.front_x;
      fz_r <= in_data.front_z;
      rx_r <= in_data.right_x;
      rz_r <= in_data.right_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: projection products and squares.
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] m_fx_r, m_fz_r, m_rx_r, m_rz_r;
  logic signed [PROD_W-1:0] m_fx_nxt, m_fz_nxt, m_rx_nxt, m_rz_nxt;
  logic [31:0]              sxx_r, szz_r, sxx_nxt, szz_nxt;
  logic                     coinc2_r, coinc2_nxt;

  assign m_fx_nxt   = PROD_W'(dx_r) * PROD_W'(fx_r);
  assign m_fz_nxt   = PROD_W'(dz_r) * PROD_W'(fz_r);
  assign m_rx_nxt   = PROD_W'(dx_r) * PROD_W'(rx_r);
  assign m_rz_nxt   = PROD_W'(dz_r) * PROD_W'(rz_r);
  assign sxx_nxt    = 32'(dx_r) * 32'(dx_r);
  assign szz_nxt    = 32'(dz_r) * 32'(dz_r);
  assign coinc2_nxt = (dx_r == '0) && (dz_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en_s2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      m_fx_r   <= m_fx_nxt;
      m_fz_r   <= m_fz_nxt;
      m_rx_r   <= m_rx_nxt;
      m_rz_r   <= m_rz_nxt;
      sxx_r    <= sxx_nxt;
      szz_r    <= szz_nxt;
      coinc2_r <= coinc2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: front and right projections and the squared length.
  // ---------------------------------------------------------------------------
  logic signed [PROJ_W-1:0] p_r, q_r, p_nxt, q_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic                     coinc3_r;

  assign p_nxt  = PROJ_W'(m_fx_r) + PROJ_W'(m_fz_r);
  assign q_nxt  = PROJ_W'(m_rx_r) + PROJ_W'(m_rz_r);
  assign sq_nxt = SQ_W'(sxx_r) + SQ_W'(szz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en_s3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s3) begin
      p_r      <= p_nxt;
      q_r      <= q_nxt;
      sq_r     <= sq_nxt;
      coinc3_r <= coinc2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: CORDIC start vector. With p negative the vector (p, |q|) is first
  // turned by -90 degrees so that every later rotation converges.
  // ---------------------------------------------------------------------------
  slot_t pipe_r [0:LOOP_STAGES];
  slot_t pipe_nxt [0:LOOP_STAGES];

  logic signed [PROJ_W-1:0] q_abs, p_neg;
  logic signed [XY_W-1:0]   q_abs_w, p_w, p_neg_w;

  always_comb begin
    q_abs   = q_r[PROJ_W-1] ? -q_r : q_r;
    p_neg   = -p_r;
    q_abs_w = XY_W'(q_abs) <<< 8;
    p_w     = XY_W'(p_r) <<< 8;
    p_neg_w = XY_W'(p_neg) <<< 8;
    if (p_r[PROJ_W-1]) begin
      pipe_nxt[0].x = q_abs_w;
      pipe_nxt[0].y = p_neg_w;
      pipe_nxt[0].z = ANG_90;
    end else begin
      pipe_nxt[0].x = p_w;
      pipe_nxt[0].y = q_abs_w;
      pipe_nxt[0].z = '0;
    end
    pipe_nxt[0].n         = sq_r;
    pipe_nxt[0].res       = '0;
    pipe_nxt[0].qneg      = q_r[PROJ_W-1];
    pipe_nxt[0].zero_bear = coinc3_r || ((p_r == '0) && (q_r == '0));
    pipe_nxt[0].coinc     = coinc3_r;
  end

  assign en_p[0] = !pv_r[0] || en_p[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r[0] <= 1'b0;
    end else if (en_p[0]) begin
      pv_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p[0]) begin
      pipe_r[0] <= pipe_nxt[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Rotation and root stages: stage k does CORDIC rotation k and resolves one
  // bit of the square root, each only while its own step count lasts.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < LOOP_STAGES; k++) begin : g_loop
    localparam logic [SQ_W-1:0] ROOT_BIT =
      (k < SQRT_STEPS) ? (SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k))) : '0;

    always_comb begin
      logic [SQ_W-1:0] trial;
      pipe_nxt[k+1] = pipe_r[k];
      trial = pipe_r[k].res | ROOT_BIT;
      if (k < CORDIC_RUN) begin
        if (!pipe_r[k].y[XY_W-1]) begin
          pipe_nxt[k+1].x = pipe_r[k].x + (pipe_r[k].y >>> k);
          pipe_nxt[k+1].y = pipe_r[k].y - (pipe_r[k].x >>> k);
          pipe_nxt[k+1].z = pipe_r[k].z + atan_ang(k);
        end else begin
          pipe_nxt[k+1].x = pipe_r[k].x - (pipe_r[k].y >>> k);
          pipe_nxt[k+1].y = pipe_r[k].y + (pipe_r[k].x >>> k);
          pipe_nxt[k+1].z = pipe_r[k].z - atan_ang(k);
        end
      end
      if (k < SQRT_STEPS) begin
        if (pipe_r[k].n >= trial) begin
          pipe_nxt[k+1].n   = pipe_r[k].n - trial;
          pipe_nxt[k+1].res = (pipe_r[k].res >> 1) | ROOT_BIT;
        end else begin
          pipe_nxt[k+1].res = pipe_r[k].res >> 1;
        end
      end
    end

    if (k + 1 < LOOP_STAGES) begin : g_en
      assign en_p[k+1] = !pv_r[k+1] || en_p[k+2];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[k+1] <= 1'b0;
      end else if (en_p[k+1]) begin
        pv_r[k+1] <= pv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en_p[k+1]) begin
        pipe_r[k+1] <= pipe_nxt[k+1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: clamp the angle to [0, 180] degrees, round to 1/128 degree,
  // apply the side of the right vector, and saturate the distance.
  // ---------------------------------------------------------------------------
  slot_t                    last;
  logic signed [Z_W-1:0]    z_clamp;
  logic [Z_W-1:0]           z_round;
  logic signed [BEAR_W-1:0] mag;
  out_item_t                out_r, out_nxt;

  always_comb begin
    last = pipe_r[LOOP_STAGES];
    if (last.z[Z_W-1]) begin
      z_clamp = '0;
    end else if (last.z > ANG_180) begin
      z_clamp = ANG_180;
    end else begin
      z_clamp = last.z;
    end
    z_round = Z_W'(z_clamp) + ROUND_HALF;
    mag     = z_round[BEAR_W+15:16];
    if (last.zero_bear) begin
      out_nxt.bearing = '0;
    end else if (last.qneg) begin
      out_nxt.bearing = -mag;
    end else begin
      out_nxt.bearing = mag;
    end
    if (last.res > SQ_W'(DIST_MAX)) begin
      out_nxt.distance = DIST_MAX;
    end else begin
      out_nxt.distance = last.res[DIST_W-1:0];
    end
    out_nxt.coincident = last.coinc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= pv_r[LOOP_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A coincident target reports neither a bearing nor a distance.
  a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coincident |-> out_data.bearing == '0 && out_data.distance == '0)
    else $error("coincident result with nonzero bearing or distance");

  // The bearing stays within a half turn either way.
  a_bear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bearing <= BEARING_MAX && out_data.bearing >= -BEARING_MAX)
    else $error("bearing out of range");

  // An accepted item always lands in the first stage.
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("accepted item not held in first stage");

  // A full last stage with a stalled output keeps its item.
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r[LOOP_STAGES] && out_valid && !out_ready |=> pv_r[LOOP_STAGES])
    else $error("item lost at pipeline tail");
`endif

endmodule
